### rtl/ira_pkg.sv
package ira_pkg;

    localparam int unsigned DEV_ADDR_W  = 7;
    localparam int unsigned ACK_LIMIT_W = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned STEP_W      = 4;

    localparam logic [DEV_ADDR_W-1:0]  DEV_ADDR_RESET  = 7'd45;
    localparam logic [ACK_LIMIT_W-1:0] ACK_LIMIT_RESET = 16'd300;

    localparam logic [STEP_W-1:0] WR_LEN = 4'd8;
    localparam logic [STEP_W-1:0] RD_LEN = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT = 2'd1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef enum logic [3:0] {
        SEG_NONE,
        SEG_START,
        SEG_WADDR,
        SEG_WREG,
        SEG_WDATA,
        SEG_RADDR,
        SEG_ACK,
        SEG_RBYTE,
        SEG_STOP
    } t_seg;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_res;

    function automatic t_seg prog_seg(input logic is_read, input logic [STEP_W-1:0] step);
        t_seg seg;
        seg = SEG_NONE;
        if (is_read) begin
            unique case (step)
                4'd1:    seg = SEG_START;
                4'd2:    seg = SEG_WADDR;
                4'd3:    seg = SEG_ACK;
                4'd4:    seg = SEG_WREG;
                4'd5:    seg = SEG_ACK;
                4'd6:    seg = SEG_START;
                4'd7:    seg = SEG_RADDR;
                4'd8:    seg = SEG_ACK;
                4'd9:    seg = SEG_RBYTE;
                4'd10:   seg = SEG_STOP;
                default: seg = SEG_NONE;
            endcase
        end else begin
            unique case (step)
                4'd1:    seg = SEG_START;
                4'd2:    seg = SEG_WADDR;
                4'd3:    seg = SEG_ACK;
                4'd4:    seg = SEG_WREG;
                4'd5:    seg = SEG_ACK;
                4'd6:    seg = SEG_WDATA;
                4'd7:    seg = SEG_ACK;
                4'd8:    seg = SEG_STOP;
                default: seg = SEG_NONE;
            endcase
        end
        return seg;
    endfunction

endpackage

### rtl/i2c_register_access_master.sv
// An item is held in the input register; its result is then registered in the output register.
// Throughput: one item per cycle unless the output stalls; the input and output registers decouple both sides.
// Each item advances the I2C sequencer by at most one bus phase.
// Reset (synchronous, active low): sequencer idle, SCL and SDA released,
// device address 45, ACK wait limit 300, both item registers empty.
module i2c_register_access_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [23:0]                      i_s_tdata,  // reg_addr[7:0], write_data[15:8], sda_in[16], zero
    input  logic [1:0]                       i_s_tuser,  // op[1:0]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [15:0]                      o_m_tdata,  // scl, sda, busy_res, done_res, read_data[11:4], ack_missing[12], zero
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ira_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import ira_pkg::*;

    logic                   r_in_valid;
    t_item                  r_in;
    logic                   r_out_valid;
    t_res                   r_out;
    logic [DEV_ADDR_W-1:0]  r_dev_addr;
    logic [ACK_LIMIT_W-1:0] r_ack_limit;
    logic                   adv;
    t_res                   res;

    assign adv         = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dev_addr  <= DEV_ADDR_RESET;
            r_ack_limit <= ACK_LIMIT_RESET;
        end else begin
            if (o_s_tready) r_in_valid <= i_s_tvalid;
            if (adv) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DEV_ADDR:  r_dev_addr  <= i_cfg_data[DEV_ADDR_W-1:0];
                    CFG_ACK_LIMIT: r_ack_limit <= i_cfg_data[ACK_LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.op         <= i_s_tuser;
            r_in.reg_addr   <= i_s_tdata[7:0];
            r_in.write_data <= i_s_tdata[15:8];
            r_in.sda_in     <= i_s_tdata[16];
        end
        if (adv) r_out <= res;
    end

    ira_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_in),
        .i_dev_addr  (r_dev_addr),
        .i_ack_limit (r_ack_limit),
        .o_res       (res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.ack_missing, r_out.read_data, r_out.done_res,
                         r_out.busy_res, r_out.sda, r_out.scl};

endmodule

### rtl/ira_core.sv
module ira_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  ira_pkg::t_item                   i_item,
    input  logic [ira_pkg::DEV_ADDR_W-1:0]   i_dev_addr,
    input  logic [ira_pkg::ACK_LIMIT_W-1:0]  i_ack_limit,
    output ira_pkg::t_res                    o_res
);
    import ira_pkg::*;

    logic [STEP_W-1:0]      r_step, n_step;
    logic [1:0]             r_phase, n_phase;
    logic [3:0]             r_bit_cnt, n_bit_cnt;
    logic [7:0]             r_shift, n_shift;
    logic                   r_is_read, n_is_read;
    logic [7:0]             r_reg, n_reg;
    logic [7:0]             r_data, n_data;
    logic [ACK_LIMIT_W-1:0] r_wait, n_wait;
    logic                   r_fail, n_fail;
    logic [7:0]             r_rx, n_rx;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   n_done;
    t_seg                   seg;
    logic [7:0]             seg_byte;
    logic [3:0]             bit_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_phase   <= '0;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_is_read <= 1'b0;
            r_reg     <= '0;
            r_data    <= '0;
            r_wait    <= '0;
            r_fail    <= 1'b0;
            r_rx      <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else if (i_adv) begin
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_is_read <= n_is_read;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_wait    <= n_wait;
            r_fail    <= n_fail;
            r_rx      <= n_rx;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

    always_comb begin
        n_step    = r_step;
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_is_read = r_is_read;
        n_reg     = r_reg;
        n_data    = r_data;
        n_wait    = r_wait;
        n_fail    = r_fail;
        n_rx      = r_rx;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_done    = 1'b0;

        // idle: pick up a new request
        if (prog_seg(r_is_read, r_step) == SEG_NONE) begin
            n_step = '0;
            if (i_item.op == OP_WRITE || i_item.op == OP_READ) begin
                n_is_read = (i_item.op == OP_READ);
                n_reg     = i_item.reg_addr;
                n_data    = i_item.write_data;
                n_fail    = 1'b0;
                n_wait    = '0;
                n_phase   = '0;
                n_bit_cnt = '0;
                n_step    = 4'd1;
            end
        end

        seg = prog_seg(n_is_read, n_step);
        unique case (seg)
            SEG_WADDR: seg_byte = {i_dev_addr, 1'b0};
            SEG_RADDR: seg_byte = {i_dev_addr, 1'b1};
            SEG_WREG:  seg_byte = n_reg;
            default:   seg_byte = n_data;
        endcase
        bit_inc = n_bit_cnt + 4'd1;

        if (n_step != '0) begin
            unique case (seg)
                SEG_START: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b1; n_phase = 2'd1;
                    end else if (n_phase == 2'd1) begin
                        n_scl = 1'b1; n_phase = 2'd2;
                    end else begin
                        n_sda = 1'b0; n_phase = '0; n_bit_cnt = '0; n_step = n_step + 4'd1;
                    end
                end
                SEG_WADDR, SEG_WREG, SEG_WDATA, SEG_RADDR: begin
                    if (n_bit_cnt < 4'd8) begin
                        if (n_phase == 2'd0) begin
                            if (n_bit_cnt == 4'd0) n_shift = seg_byte;
                            n_scl = 1'b0; n_phase = 2'd1;
                        end else if (n_phase == 2'd1) begin
                            n_sda   = n_shift[7];
                            n_shift = {n_shift[6:0], 1'b0};
                            n_phase = 2'd2;
                        end else begin
                            n_scl = 1'b1; n_phase = 2'd0; n_bit_cnt = bit_inc;
                        end
                    end else if (n_phase == 2'd0) begin
                        n_scl = 1'b0; n_phase = 2'd1;
                    end else begin
                        n_sda = 1'b1; n_phase = '0; n_bit_cnt = '0; n_step = n_step + 4'd1;
                    end
                end
                SEG_ACK: begin
                    if (n_phase == 2'd0) begin
                        n_scl = 1'b1; n_wait = '0; n_phase = 2'd1;
                    end else if (i_item.sda_in && n_wait < i_ack_limit) begin
                        n_wait = n_wait + 1'b1;
                    end else begin
                        if (i_item.sda_in) n_fail = 1'b1;
                        n_scl = 1'b0; n_phase = '0; n_bit_cnt = '0; n_step = n_step + 4'd1;
                    end
                end
                SEG_RBYTE: begin
                    if (n_phase == 2'd0) begin
                        n_scl = 1'b0; n_phase = 2'd1;
                    end else if (n_phase == 2'd1) begin
                        n_sda = 1'b1; n_phase = 2'd2;
                    end else if (n_phase == 2'd2) begin
                        n_scl = 1'b1; n_phase = 2'd3;
                    end else begin
                        n_shift   = {n_shift[6:0], i_item.sda_in};
                        n_scl     = 1'b0;
                        n_bit_cnt = bit_inc;
                        if (bit_inc >= 4'd8) begin
                            n_rx = n_shift; n_phase = '0; n_bit_cnt = '0; n_step = n_step + 4'd1;
                        end else begin
                            n_phase = 2'd2;
                        end
                    end
                end
                SEG_STOP: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b0; n_phase = 2'd1;
                    end else if (n_phase == 2'd1) begin
                        n_scl = 1'b1; n_phase = 2'd2;
                    end else begin
                        n_sda = 1'b1; n_phase = '0; n_bit_cnt = '0; n_step = n_step + 4'd1;
                        n_done = 1'b1;
                    end
                end
                default: n_step = '0;
            endcase
            if (n_step > (n_is_read ? RD_LEN : WR_LEN)) n_step = '0;
        end

        o_res.scl         = n_scl;
        o_res.sda         = n_sda;
        o_res.busy_res    = (n_step != '0);
        o_res.done_res    = n_done;
        o_res.read_data   = n_rx;
        o_res.ack_missing = n_fail;
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> !o_res.busy_res)
        else $error("stop completed while still busy");
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == '0) |-> (r_scl && r_sda))
        else $error("bus lines held low while idle");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'd8)
        else $error("bit counter out of range");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= (r_is_read ? RD_LEN : WR_LEN))
        else $error("sequence step past end of program");

endmodule

### bench/i2c_bus_drive_checker.sv
`timescale 1ns / 100ps

module i2c_bus_drive_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [23:0]                   i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [15:0]                   i_m_tdata,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [ira_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output int                            o_pending,
    output int                            o_failures,
    output logic                          o_bus_idle,
    output int                            o_items,
    output int                            o_transfers,
    output int                            o_nack_transfers
);
    import ira_pkg::*;

    logic [6:0]  dev_addr;
    logic [15:0] wait_limit;

    logic [4:0]  step;
    logic [1:0]  phase;
    logic [3:0]  nbits;
    logic [7:0]  shreg;
    logic        rd_mode;
    logic [7:0]  reg_q;
    logic [7:0]  data_q;
    logic [15:0] wait_cnt;
    logic        ack_fail;
    logic [7:0]  rx_byte;
    logic        scl_q;
    logic        sda_q;

    t_res bus_drive_q[$];

    function void model_reset();
        dev_addr   = DEV_ADDR_RESET;
        wait_limit = ACK_LIMIT_RESET;
        step       = '0;
        phase      = '0;
        nbits      = '0;
        shreg      = '0;
        rd_mode    = 1'b0;
        reg_q      = '0;
        data_q     = '0;
        wait_cnt   = '0;
        ack_fail   = 1'b0;
        rx_byte    = '0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
    endfunction

    function t_seg seg_now();
        t_seg s;
        s = SEG_NONE;
        if (rd_mode) begin
            case (step)
                5'd1:  s = SEG_START;
                5'd2:  s = SEG_WADDR;
                5'd3:  s = SEG_ACK;
                5'd4:  s = SEG_WREG;
                5'd5:  s = SEG_ACK;
                5'd6:  s = SEG_START;
                5'd7:  s = SEG_RADDR;
                5'd8:  s = SEG_ACK;
                5'd9:  s = SEG_RBYTE;
                5'd10: s = SEG_STOP;
                default: s = SEG_NONE;
            endcase
        end else begin
            case (step)
                5'd1:  s = SEG_START;
                5'd2:  s = SEG_WADDR;
                5'd3:  s = SEG_ACK;
                5'd4:  s = SEG_WREG;
                5'd5:  s = SEG_ACK;
                5'd6:  s = SEG_WDATA;
                5'd7:  s = SEG_ACK;
                5'd8:  s = SEG_STOP;
                default: s = SEG_NONE;
            endcase
        end
        return s;
    endfunction

    function void step_advance();
        phase = '0;
        nbits = '0;
        step  = step + 5'd1;
        if (step > (rd_mode ? 5'(RD_LEN) : 5'(WR_LEN)))
            step = '0;
    endfunction

    function logic [7:0] byte_for(input t_seg seg);
        case (seg)
            SEG_WADDR: return {dev_addr, 1'b0};
            SEG_RADDR: return {dev_addr, 1'b1};
            SEG_WREG:  return reg_q;
            default:   return data_q;
        endcase
    endfunction

    // one bus phase; returns 1 when the stop condition completes
    function logic bus_tick(input logic sda_in);
        t_seg seg;
        logic fin;
        seg = seg_now();
        fin = 1'b0;
        case (seg)
            SEG_START: begin
                if (phase == 2'd0) begin
                    sda_q = 1'b1; phase = 2'd1;
                end else if (phase == 2'd1) begin
                    scl_q = 1'b1; phase = 2'd2;
                end else begin
                    sda_q = 1'b0; step_advance();
                end
            end
            SEG_WADDR, SEG_WREG, SEG_WDATA, SEG_RADDR: begin
                if (nbits < 4'd8) begin
                    if (phase == 2'd0) begin
                        if (nbits == 4'd0) shreg = byte_for(seg);
                        scl_q = 1'b0; phase = 2'd1;
                    end else if (phase == 2'd1) begin
                        sda_q = shreg[7];
                        shreg = {shreg[6:0], 1'b0};
                        phase = 2'd2;
                    end else begin
                        scl_q = 1'b1; phase = 2'd0; nbits = nbits + 4'd1;
                    end
                end else if (phase == 2'd0) begin
                    scl_q = 1'b0; phase = 2'd1;
                end else begin
                    sda_q = 1'b1; step_advance();
                end
            end
            SEG_ACK: begin
                if (phase == 2'd0) begin
                    scl_q = 1'b1; wait_cnt = '0; phase = 2'd1;
                end else if (sda_in && wait_cnt < wait_limit) begin
                    wait_cnt = wait_cnt + 16'd1;
                end else begin
                    if (sda_in) ack_fail = 1'b1;
                    scl_q = 1'b0;
                    step_advance();
                end
            end
            SEG_RBYTE: begin
                if (phase == 2'd0) begin
                    scl_q = 1'b0; phase = 2'd1;
                end else if (phase == 2'd1) begin
                    sda_q = 1'b1; phase = 2'd2;
                end else if (phase == 2'd2) begin
                    scl_q = 1'b1; phase = 2'd3;
                end else begin
                    shreg = {shreg[6:0], sda_in};
                    scl_q = 1'b0;
                    nbits = nbits + 4'd1;
                    if (nbits >= 4'd8) begin
                        rx_byte = shreg;
                        step_advance();
                    end else begin
                        phase = 2'd2;
                    end
                end
            end
            SEG_STOP: begin
                if (phase == 2'd0) begin
                    sda_q = 1'b0; phase = 2'd1;
                end else if (phase == 2'd1) begin
                    scl_q = 1'b1; phase = 2'd2;
                end else begin
                    sda_q = 1'b1; step_advance(); fin = 1'b1;
                end
            end
            default: step = '0;
        endcase
        return fin;
    endfunction

    function t_res predict_bus_drive(input t_item it);
        t_res r;
        logic fin;
        if (seg_now() == SEG_NONE) begin
            step = '0;
            if (it.op == OP_WRITE || it.op == OP_READ) begin
                rd_mode  = (it.op == OP_READ);
                reg_q    = it.reg_addr;
                data_q   = it.write_data;
                ack_fail = 1'b0;
                wait_cnt = '0;
                phase    = '0;
                nbits    = '0;
                step     = 5'd1;
            end
        end
        fin = 1'b0;
        if (step != 5'd0) fin = bus_tick(it.sda_in);
        r.scl         = scl_q;
        r.sda         = sda_q;
        r.busy_res    = (step != 5'd0);
        r.done_res    = fin;
        r.read_data   = rx_byte;
        r.ack_missing = ack_fail;
        return r;
    endfunction

    function void field_check(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            o_failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_item it;
        t_res  want;
        t_res  got;
        if (!i_rst_n) begin
            model_reset();
            bus_drive_q.delete();
            o_failures       = 0;
            o_items          = 0;
            o_transfers      = 0;
            o_nack_transfers = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEV_ADDR:  dev_addr   = i_cfg_data[6:0];
                    CFG_ACK_LIMIT: wait_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.scl         = i_m_tdata[0];
                got.sda         = i_m_tdata[1];
                got.busy_res    = i_m_tdata[2];
                got.done_res    = i_m_tdata[3];
                got.read_data   = i_m_tdata[11:4];
                got.ack_missing = i_m_tdata[12];
                if (bus_drive_q.size() == 0) begin
                    o_failures++;
                    $display("%0t: unexpected item, expected none, got %0h", $time, i_m_tdata);
                end else begin
                    want = bus_drive_q.pop_front();
                    field_check("scl", 8'(want.scl), 8'(got.scl));
                    field_check("sda", 8'(want.sda), 8'(got.sda));
                    field_check("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    field_check("done_res", 8'(want.done_res), 8'(got.done_res));
                    field_check("read_data", want.read_data, got.read_data);
                    field_check("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
                    if (want.done_res) begin
                        o_transfers++;
                        if (want.ack_missing) o_nack_transfers++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                it.op         = i_s_tuser;
                it.reg_addr   = i_s_tdata[7:0];
                it.write_data = i_s_tdata[15:8];
                it.sda_in     = i_s_tdata[16];
                bus_drive_q.push_back(predict_bus_drive(it));
                o_items++;
            end
        end
        o_pending  = bus_drive_q.size();
        o_bus_idle = (seg_now() == SEG_NONE);
    end

endmodule

### bench/i2c_register_access_master_tb.sv
`timescale 1ns / 100ps

module i2c_register_access_master_tb;
    import ira_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata   = '0;  // reg_addr, write_data, sda_in, zero
    logic [1:0]           i_s_tuser   = '0;  // op
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [15:0]          o_m_tdata;         // scl, sda, busy, done, read_data, ack_missing
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    int   pending;
    int   failures;
    logic bus_idle;
    int   items;
    int   transfers;
    int   nack_transfers;

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   sda_high_pct = 50;
    int   req_pct      = 10;
    logic hold_req     = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    i2c_register_access_master i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    i2c_bus_drive_checker bus_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_failures       (failures),
        .o_bus_idle       (bus_idle),
        .o_items          (items),
        .o_transfers      (transfers),
        .o_nack_transfers (nack_transfers)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen  <= hold_req;
            hold_left  <= 300;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] wd,
                             input logic sda);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_tdata  <= {7'd0, sda, wd, ra};
        i_s_tuser  <= op;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic set_config(input logic [6:0] addr, input logic [15:0] lim);
        i_cfg_index <= CFG_DEV_ADDR;
        i_cfg_data  <= {9'd0, addr};
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_ACK_LIMIT;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // random items, then ticks until the bus sequencer is back in idle
    task automatic run_phase(input int n);
        logic [1:0] op;
        repeat (n) begin
            op = ($urandom_range(99) < req_pct) ? 2'($urandom_range(3, 1)) : OP_TICK;
            send_item(op, 8'($urandom), 8'($urandom), $urandom_range(99) < sda_high_pct);
        end
        settle();
        while (!bus_idle)
            send_item(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        settle();
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme address, zero ACK wait, unused op, request while busy
        set_config(7'h7F, 16'd0);
        send_item(OP_TICK, 8'h00, 8'h00, 1'b0);
        send_item(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
        send_item(OP_WRITE, 8'hFF, 8'h00, 1'b1);
        send_item(OP_READ, 8'h00, 8'hFF, 1'b0);
        send_item(OP_SPARE, 8'hA5, 8'h5A, 1'b1);
        for (int k = 0; k < 16; k++)
            send_item(OP_TICK, 8'(k), 8'(~k), 1'(k));

        run_phase(170);

        set_config(7'h00, 16'hFFFF);
        tx_idle_pct  = 49;
        sda_high_pct = 30;
        run_phase(170);

        set_config(7'($urandom), 16'd300);
        tx_idle_pct  = 0;
        rx_stall_pct = 49;
        sda_high_pct = 50;
        hold_req     = ~hold_req;
        run_phase(170);

        set_config(7'($urandom), 16'd2);
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
        sda_high_pct = 85;
        run_phase(170);

        set_config(7'($urandom), 16'($urandom_range(20)));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        sda_high_pct = 50;
        run_phase(170);

        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d items over five settings (address 0..127, ACK wait 0..65535).",
                 items);
        $display("Bus transfers completed: %0d, of which %0d saw a missed ACK.",
                 transfers, nack_transfers);
        if (failures == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
